// ===== sv/cas_pkg.sv =====
`default_nettype none

package cas_pkg;

   // default counter width for settle and timeout counters
   localparam int TICK_COUNT_WIDTH_DEF = 16;

   // configured tick values are always this wide
   localparam int TICKS_WIDTH = 16;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   // stream payload widths
   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 8;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_IO_PRESENT        = 3'd0,
      REG_INVERT_ROLES      = 3'd1,
      REG_TIMEOUT_ENABLE    = 3'd2,
      REG_FWD_SETTLE_TICKS  = 3'd3,
      REG_BWD_SETTLE_TICKS  = 3'd4,
      REG_FWD_TIMEOUT_TICKS = 3'd5,
      REG_BWD_TIMEOUT_TICKS = 3'd6
   } csr_index_type;

   // io_present bit positions
   localparam int IO_FWD_SENSOR = 0;
   localparam int IO_BWD_SENSOR = 1;
   localparam int IO_FWD_VALVE  = 2;
   localparam int IO_BWD_VALVE  = 3;

   // error codes
   localparam logic [1:0] ERR_NONE        = 2'd0;
   localparam logic [1:0] ERR_FWD_TIMEOUT = 2'd1;
   localparam logic [1:0] ERR_BWD_TIMEOUT = 2'd2;

endpackage

`default_nettype wire

// ===== sv/cas_on_delay.sv =====
`default_nettype none

// Saturating on-delay counter. fire is valid in the cycle the request is taken.
module cas_on_delay
   import cas_pkg::*;
#(
   parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,        // request accepted
   input  wire logic                   run,         // evaluate this tick
   input  wire logic                   zero_first,  // count reads 0 before evaluation
   input  wire logic                   level,
   input  wire logic [TICKS_WIDTH-1:0] ticks,
   output logic                        fire
);

   localparam int CMP_WIDTH = (TICK_COUNT_WIDTH > TICKS_WIDTH) ? TICK_COUNT_WIDTH
                                                                : TICKS_WIDTH;

   logic [TICK_COUNT_WIDTH-1:0] count_ff, count_in;
   logic [TICK_COUNT_WIDTH-1:0] count_eff;
   logic [TICK_COUNT_WIDTH-1:0] count_next;

   // count seen by this tick, and its follower
   always_comb begin
      count_eff = zero_first ? '0 : count_ff;
      fire      = level && (CMP_WIDTH'(count_eff) >= CMP_WIDTH'(ticks));
      if (!level) begin
         count_next = '0;
      end else if (count_eff != {TICK_COUNT_WIDTH{1'b1}}) begin
         count_next = count_eff + 1'b1;
      end else begin
         count_next = count_eff;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (step) begin
         if (run) begin
            count_in = count_next;
         end else if (zero_first) begin
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/cylinder_actuator_supervisor.sv =====
// The response to a request is registered and valid in the cycle after the request is accepted.
// Throughput: one request per cycle while the response is taken; all state updates in the accept cycle,
// the response sits in a single output register that frees as it is taken.
// Reset: synchronous, active high; registers return to their reset values,
// counters, latches and valve states clear, and the response register empties.
`default_nettype none

module cylinder_actuator_supervisor
   import cas_pkg::*;
#(
   parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request stream
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // [0] fwd_sensor, [1] bwd_sensor, [2] has_command, [3] command_forward,
   // [4] clear_error, [7:5] zero
   input  wire logic [REQ_DATA_WIDTH-1:0]  req_tdata,
   // response stream
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // [0] fwd_valve, [1] bwd_valve, [2] fwd_done, [3] bwd_done,
   // [4] command_done, [5] timed_out, [7:6] error_code
   output logic [RSP_DATA_WIDTH-1:0]       rsp_tdata,
   // configuration writes
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   // configuration registers
   logic [3:0]             io_present_ff;
   logic                   invert_roles_ff;
   logic                   timeout_enable_ff;
   logic [TICKS_WIDTH-1:0] fwd_settle_ticks_ff, bwd_settle_ticks_ff;
   logic [TICKS_WIDTH-1:0] fwd_timeout_ticks_ff, bwd_timeout_ticks_ff;

   // supervisor state
   logic fwd_valve_ff, fwd_valve_in;
   logic bwd_valve_ff, bwd_valve_in;
   logic fwd_latched_ff, fwd_latched_in;
   logic bwd_latched_ff, bwd_latched_in;
   logic fwd_reached_ff, fwd_reached_in;
   logic bwd_reached_ff, bwd_reached_in;

   // response register
   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic accept;
   logic sf, sb, has_cmd, cmd_fwd, clr;
   logic inv, pxf, pxb, pyf, pyb;
   logic lxf, lxb, lyf, lyb, any_valve;
   logic dfy, dby, dfx, dbx;
   logic vfx, vbx, vfy, vby;
   logic odfx, odbx, ftoe, btoe, moving;
   logic cmd_done;
   logic [1:0] err_code;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign sf      = req_tdata[0];
   assign sb      = req_tdata[1];
   assign has_cmd = req_tdata[2];
   assign cmd_fwd = req_tdata[3];
   assign clr     = req_tdata[4];

   // role view of present I/O
   assign inv = invert_roles_ff;
   assign pxf = io_present_ff[IO_FWD_SENSOR];
   assign pxb = io_present_ff[IO_BWD_SENSOR];
   assign pyf = io_present_ff[IO_FWD_VALVE];
   assign pyb = io_present_ff[IO_BWD_VALVE];
   assign lxf = inv ? pxb : pxf;
   assign lxb = inv ? pxf : pxb;
   assign lyf = inv ? pyb : pyf;
   assign lyb = inv ? pyf : pyb;
   assign any_valve = lyf || lyb;

   // command drives present valves (role view), then map back to physical
   always_comb begin
      dfy = inv ? bwd_valve_ff : fwd_valve_ff;
      dby = inv ? fwd_valve_ff : bwd_valve_ff;
      if (has_cmd && lyf) begin
         dfy = cmd_fwd;
      end
      if (has_cmd && lyb) begin
         dby = !cmd_fwd;
      end
      fwd_valve_in = fwd_valve_ff;
      bwd_valve_in = bwd_valve_ff;
      if (accept) begin
         fwd_valve_in = inv ? dby : dfy;
         bwd_valve_in = inv ? dfy : dby;
      end
   end

   // virtual sensors and valves
   always_comb begin
      dfx = inv ? sb : sf;
      dbx = inv ? sf : sb;
      if (lxf) begin
         vfx = dfx;
      end else if (lxb) begin
         vfx = !dbx;
      end else if (lyf) begin
         vfx = dfy;
      end else begin
         vfx = !dby;
      end
      if (lxb) begin
         vbx = dbx;
      end else if (lxf) begin
         vbx = !dfx;
      end else if (lyb) begin
         vbx = dby;
      end else begin
         vbx = !dfy;
      end
      vfy = lyf ? dfy : !dby;
      vby = lyb ? dby : !dfy;
   end

   // position qualification
   cas_on_delay #(.TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)) u_fwd_settle (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .run        (any_valve),
      .zero_first (1'b0),
      .level      (vfx),
      .ticks      (fwd_settle_ticks_ff),
      .fire       (odfx)
   );

   cas_on_delay #(.TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)) u_bwd_settle (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .run        (any_valve),
      .zero_first (1'b0),
      .level      (vbx),
      .ticks      (bwd_settle_ticks_ff),
      .fire       (odbx)
   );

   // position does not match the valves, when timeouts are enabled
   assign moving = timeout_enable_ff &&
                   ((odfx == odbx) || (vfy && (odbx || !odfx)) ||
                    (vby && (odfx || !odbx)));

   cas_on_delay #(.TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)) u_fwd_timeout (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .run        (any_valve),
      .zero_first (clr || !any_valve),
      .level      (moving),
      .ticks      (fwd_timeout_ticks_ff),
      .fire       (ftoe)
   );

   cas_on_delay #(.TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)) u_bwd_timeout (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .run        (any_valve),
      .zero_first (clr || !any_valve),
      .level      (moving),
      .ticks      (bwd_timeout_ticks_ff),
      .fire       (btoe)
   );

   // latches and reached flags; without valves the latches clear and the reached flags hold
   always_comb begin
      fwd_latched_in = fwd_latched_ff;
      bwd_latched_in = bwd_latched_ff;
      fwd_reached_in = fwd_reached_ff;
      bwd_reached_in = bwd_reached_ff;
      if (accept) begin
         if (clr || !any_valve) begin
            fwd_latched_in = 1'b0;
            bwd_latched_in = 1'b0;
         end
         if (any_valve) begin
            if (ftoe) begin
               fwd_latched_in = 1'b1;
            end
            if (btoe) begin
               bwd_latched_in = 1'b1;
            end
            fwd_reached_in = odfx && !(ftoe || btoe);
            bwd_reached_in = odbx && !(ftoe || btoe);
         end
      end
   end

   // response word
   always_comb begin
      if (!has_cmd) begin
         cmd_done = 1'b0;
      end else if (cmd_fwd) begin
         cmd_done = fwd_reached_in && !bwd_reached_in;
      end else begin
         cmd_done = !fwd_reached_in && bwd_reached_in;
      end
      if (fwd_latched_in) begin
         err_code = ERR_FWD_TIMEOUT;
      end else if (bwd_latched_in) begin
         err_code = ERR_BWD_TIMEOUT;
      end else begin
         err_code = ERR_NONE;
      end
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      if (accept) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {err_code,
                          fwd_latched_in || bwd_latched_in,
                          cmd_done,
                          !fwd_reached_in && bwd_reached_in,
                          fwd_reached_in && !bwd_reached_in,
                          pyb && bwd_valve_in,
                          pyf && fwd_valve_in};
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         io_present_ff        <= 4'hF;
         invert_roles_ff      <= 1'b0;
         timeout_enable_ff    <= 1'b0;
         fwd_settle_ticks_ff  <= '0;
         bwd_settle_ticks_ff  <= '0;
         fwd_timeout_ticks_ff <= '0;
         bwd_timeout_ticks_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            REG_IO_PRESENT:        io_present_ff        <= csr_wdata[3:0];
            REG_INVERT_ROLES:      invert_roles_ff      <= csr_wdata[0];
            REG_TIMEOUT_ENABLE:    timeout_enable_ff    <= csr_wdata[0];
            REG_FWD_SETTLE_TICKS:  fwd_settle_ticks_ff  <= csr_wdata[TICKS_WIDTH-1:0];
            REG_BWD_SETTLE_TICKS:  bwd_settle_ticks_ff  <= csr_wdata[TICKS_WIDTH-1:0];
            REG_FWD_TIMEOUT_TICKS: fwd_timeout_ticks_ff <= csr_wdata[TICKS_WIDTH-1:0];
            REG_BWD_TIMEOUT_TICKS: bwd_timeout_ticks_ff <= csr_wdata[TICKS_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // state and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valve_ff   <= 1'b0;
         bwd_valve_ff   <= 1'b0;
         fwd_latched_ff <= 1'b0;
         bwd_latched_ff <= 1'b0;
         fwd_reached_ff <= 1'b0;
         bwd_reached_ff <= 1'b0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         fwd_valve_ff   <= fwd_valve_in;
         bwd_valve_ff   <= bwd_valve_in;
         fwd_latched_ff <= fwd_latched_in;
         bwd_latched_ff <= bwd_latched_in;
         fwd_reached_ff <= fwd_reached_in;
         bwd_reached_ff <= bwd_reached_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

`default_nettype wire
